// File: hdl/accel_tilt_quaternion_defines.svh
// assertion macros for the accelerometer tilt quaternion block
`ifndef ACCEL_TILT_QUATERNION_DEFINES_SVH
`define ACCEL_TILT_QUATERNION_DEFINES_SVH

`ifndef SYNTHESIS
`define ATQ_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("accel_tilt_quaternion check failed");
`define ATQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("accel_tilt_quaternion sequencing check failed");
`else
`define ATQ_ASSERT(label, prop)
`define ATQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/atq_pkg.sv
// shared types, constants and tables of the accelerometer tilt quaternion block
`default_nettype none
package atq_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MAX_SAMPLE_W     = 24;

    localparam int IN_W    = 16;
    localparam int QUAT_W  = 16;
    localparam int ROLL_W  = 15;
    localparam int PITCH_W = 14;
    localparam int STATE_W = 26;
    localparam int CW      = 32;
    localparam int ZW      = 22;
    localparam int STEP_W  = 5;
    localparam int ATAN_W  = 17;

    localparam logic signed [63:0] W_OLD        = 64'sd58982;
    localparam logic signed [63:0] W_NEW        = 64'sd6554;
    localparam logic signed [63:0] INV_GAIN_Q16 = 64'sd39797;
    localparam logic signed [CW-1:0] INV_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [ZW-1:0] PI_Q16     = 22'sd205887;

    localparam logic signed [ROLL_W-1:0]  ROLL_LIM  = 15'sd12868;
    localparam logic signed [PITCH_W-1:0] PITCH_LIM = 14'sd6434;
    localparam logic signed [QUAT_W-1:0]  QUAT_LIM  = 16'sd16384;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_FILT_MUL,
        OP_FILT_ACC,
        OP_V1_INIT,
        OP_V2_INIT,
        OP_R1_INIT,
        OP_R2_INIT,
        OP_ITER,
        OP_SCALE_MUL,
        OP_Q_MUL,
        OP_Q_RND,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op            op;
        logic [1:0]        axis;
        logic [STEP_W-1:0] step;
        logic [1:0]        qsel;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

    function automatic logic [ATAN_W-1:0] atan_q16(input logic [STEP_W-1:0] k);
        logic [ATAN_W-1:0] v;
        case (k)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30386;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: hdl/atq_in_if.sv
// sample channel carrying one three-axis accelerometer word
`default_nettype none
interface atq_in_if;
    import atq_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] accel_x;
    logic signed [IN_W-1:0] accel_y;
    logic signed [IN_W-1:0] accel_z;
    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface
`default_nettype wire

// File: hdl/atq_out_if.sv
// result channel carrying one quaternion and angle word
`default_nettype none
interface atq_out_if;
    import atq_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [QUAT_W-1:0]  quat_w;
    logic signed [QUAT_W-1:0]  quat_x;
    logic signed [QUAT_W-1:0]  quat_y;
    logic signed [QUAT_W-1:0]  quat_z;
    logic signed [ROLL_W-1:0]  roll_angle;
    logic signed [PITCH_W-1:0] pitch_angle;
    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, output roll_angle, output pitch_angle, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, input roll_angle, input pitch_angle, output ready);
endinterface
`default_nettype wire

// File: hdl/accel_tilt_quaternion.sv
// accelerometer tilt to quaternion: smoothing filter, cordic angles, quaternion terms
// one word at a time: a new sample is not taken until the result of the last is loaded
// the shared cordic unit runs four passes of CORDIC_STEPS iterations each per word
// the next word can be accepted from the cycle the result is loaded, held off while the output stalls
// synchronous active-low reset clears the filter state and the sequencer
`default_nettype none
`include "accel_tilt_quaternion_defines.svh"
module accel_tilt_quaternion #(
    parameter int SAMPLE_WIDTH = atq_pkg::SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = atq_pkg::CORDIC_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    atq_in_if.sink    i_sample,
    atq_out_if.source o_result
);
    import atq_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       ready;
    logic       accept;

    assign accept         = i_sample.valid && ready;
    assign i_sample.ready = ready;

    atq_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_status (status),
        .o_ready  (ready),
        .o_cmd    (cmd)
    );

    atq_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept),
        .i_accel_x (i_sample.accel_x),
        .i_accel_y (i_sample.accel_y),
        .i_accel_z (i_sample.accel_z),
        .i_cmd     (cmd),
        .o_status  (status),
        .o_result  (o_result)
    );

    `ATQ_ASSERT_NEXT(a_busy_after_accept, accept, !i_sample.ready)
    `ATQ_ASSERT(a_roll_range, o_result.valid |-> (o_result.roll_angle <= ROLL_LIM && o_result.roll_angle >= -ROLL_LIM))
    `ATQ_ASSERT(a_pitch_range, o_result.valid |-> (o_result.pitch_angle <= PITCH_LIM && o_result.pitch_angle >= -PITCH_LIM))
    `ATQ_ASSERT(a_quat_w_range, o_result.valid |-> (o_result.quat_w <= QUAT_LIM && o_result.quat_w >= -QUAT_LIM))

endmodule
`default_nettype wire

// File: hdl/atq_ctrl.sv
// sequencer issuing datapath commands for filter, cordic passes and quaternion terms
`default_nettype none
module atq_ctrl #(
    parameter int CORDIC_STEPS = atq_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  atq_pkg::t_dp_status i_status,
    output logic                o_ready,
    output atq_pkg::t_dp_cmd    o_cmd
);
    import atq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILT,
        S_CORDIC,
        S_SCALE,
        S_QUAT,
        S_DONE
    } t_state;

    t_state     r_state;
    t_dp_cmd    r_cmd;
    logic       r_ready;
    logic [1:0] r_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= '{op: OP_NONE, axis: '0, step: '0, qsel: '0};
            r_ready <= 1'b1;
            r_pass  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_cmd.op <= OP_NONE;
                    if (i_accept) begin
                        r_ready    <= 1'b0;
                        r_cmd.op   <= OP_FILT_MUL;
                        r_cmd.axis <= '0;
                        r_state    <= S_FILT;
                    end
                end
                S_FILT: begin
                    if (r_cmd.op == OP_FILT_MUL) begin
                        r_cmd.op <= OP_FILT_ACC;
                    end else if (r_cmd.axis == 2'd2) begin
                        r_cmd.op <= OP_V1_INIT;
                        r_pass   <= 2'd0;
                        r_state  <= S_CORDIC;
                    end else begin
                        r_cmd.op   <= OP_FILT_MUL;
                        r_cmd.axis <= r_cmd.axis + 2'd1;
                    end
                end
                S_CORDIC: begin
                    if (r_cmd.op != OP_ITER) begin
                        r_cmd.op   <= OP_ITER;
                        r_cmd.step <= '0;
                    end else if (r_cmd.step != STEP_W'(CORDIC_STEPS - 1)) begin
                        r_cmd.step <= r_cmd.step + 1'b1;
                    end else begin
                        case (r_pass)
                            2'd0: begin
                                r_cmd.op <= OP_SCALE_MUL;
                                r_state  <= S_SCALE;
                            end
                            2'd1: begin
                                r_cmd.op <= OP_R1_INIT;
                                r_pass   <= 2'd2;
                            end
                            2'd2: begin
                                r_cmd.op <= OP_R2_INIT;
                                r_pass   <= 2'd3;
                            end
                            default: begin
                                r_cmd.op   <= OP_Q_MUL;
                                r_cmd.qsel <= '0;
                                r_state    <= S_QUAT;
                            end
                        endcase
                    end
                end
                S_SCALE: begin
                    r_cmd.op <= OP_V2_INIT;
                    r_pass   <= 2'd1;
                    r_state  <= S_CORDIC;
                end
                S_QUAT: begin
                    if (r_cmd.op == OP_Q_MUL) begin
                        r_cmd.op <= OP_Q_RND;
                    end else if (r_cmd.qsel == 2'd3) begin
                        r_cmd.op <= OP_NONE;
                        r_state  <= S_DONE;
                    end else begin
                        r_cmd.op   <= OP_Q_MUL;
                        r_cmd.qsel <= r_cmd.qsel + 2'd1;
                    end
                end
                S_DONE: begin
                    r_cmd.op <= OP_NONE;
                    if (!i_status.out_busy) begin
                        r_cmd.op <= OP_OUT;
                        r_ready  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_cmd.op <= OP_NONE;
                    r_ready  <= 1'b1;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready = r_ready;
    assign o_cmd   = r_cmd;

endmodule
`default_nettype wire

// File: hdl/atq_datapath.sv
// filter state, shared cordic unit, multiplier and output word register
`default_nettype none
module atq_datapath #(
    parameter int SAMPLE_WIDTH = atq_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic signed [atq_pkg::IN_W-1:0] i_accel_x,
    input  logic signed [atq_pkg::IN_W-1:0] i_accel_y,
    input  logic signed [atq_pkg::IN_W-1:0] i_accel_z,
    input  atq_pkg::t_dp_cmd            i_cmd,
    output atq_pkg::t_dp_status         o_status,
    atq_out_if.source                   o_result
);
    import atq_pkg::*;

    localparam int FRAC = STATE_W - SAMPLE_WIDTH;

    logic signed [STATE_W-1:0] r_sm [3];
    logic signed [STATE_W-1:0] r_smp [3];
    logic signed [63:0]        r_prod;
    logic signed [CW-1:0]      r_cx, r_cy;
    logic signed [ZW-1:0]      r_cz;
    logic                      r_rot, r_zero;
    logic signed [ZW-1:0]      r_roll, r_pitch;
    logic signed [CW-1:0]      r_cr, r_sr;
    logic [QUAT_W-1:0]         r_q [4];
    logic                      r_out_valid;
    logic signed [QUAT_W-1:0]  r_ow, r_ox, r_oy, r_oz;
    logic signed [ROLL_W-1:0]  r_oroll;
    logic signed [PITCH_W-1:0] r_opitch;

    logic signed [STATE_W-1:0] smp_x, smp_y, smp_z;
    logic signed [STATE_W-1:0] f_new;
    logic signed [CW-1:0]      vi_x, vi_y, it_dx, it_dy;
    logic [ZW-1:0]             it_t;
    logic                      it_sigma;
    logic signed [63:0]        q_a, q_b;
    logic [QUAT_W-1:0]         q_new;
    logic signed [ROLL_W-1:0]  a_roll;
    logic signed [PITCH_W-1:0] a_pitch;

    function automatic logic signed [STATE_W-1:0] to_fixed(input logic [IN_W-1:0] f);
        logic [MAX_SAMPLE_W-1:0] z;
        logic [SAMPLE_WIDTH-1:0] s;
        z = MAX_SAMPLE_W'(f);
        s = z[SAMPLE_WIDTH-1:0];
        return $signed({s, {FRAC{1'b0}}});
    endfunction

    assign smp_x = to_fixed(i_accel_x);
    assign smp_y = to_fixed(i_accel_y);
    assign smp_z = to_fixed(i_accel_z);

    // exponential smoothing, second half
    always_comb begin
        logic signed [63:0] acc;
        logic signed [63:0] sh;
        acc = r_prod + 64'(r_smp[i_cmd.axis]) * W_NEW + 64'sd32768;
        sh  = acc >>> 16;
        if (sh > 64'sd33554431) begin
            f_new = {1'b0, {(STATE_W-1){1'b1}}};
        end else if (sh < -64'sd33554432) begin
            f_new = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            f_new = sh[STATE_W-1:0];
        end
    end

    // vectoring start vector
    always_comb begin
        logic signed [63:0] r_scaled;
        r_scaled = (r_prod + 64'sd32768) >>> 16;
        if (i_cmd.op == OP_V1_INIT) begin
            vi_x = CW'(r_sm[2]);
            vi_y = CW'(r_sm[1]);
        end else begin
            vi_x = r_scaled[CW-1:0];
            vi_y = CW'(r_sm[0]);
        end
    end

    // one cordic micro-rotation
    always_comb begin
        it_dx = r_cy >>> i_cmd.step;
        it_dy = r_cx >>> i_cmd.step;
        it_t  = ZW'(atan_q16(i_cmd.step));
        if (r_rot) begin
            it_t = it_t << 1;
        end
        it_sigma = r_rot ? !r_cz[ZW-1] : r_cy[CW-1];
    end

    always_comb begin
        case (i_cmd.qsel)
            2'd0:    begin q_a = 64'(r_cr);  q_b = 64'(r_cx); end
            2'd1:    begin q_a = 64'(r_sr);  q_b = 64'(r_cx); end
            2'd2:    begin q_a = 64'(r_cr);  q_b = 64'(r_cy); end
            default: begin q_a = -64'(r_sr); q_b = 64'(r_cy); end
        endcase
    end

    always_comb begin
        logic signed [63:0] v;
        v = (r_prod + (64'sd1 <<< 45)) >>> 46;
        if (v > 64'sd16384) begin
            q_new = QUAT_LIM;
        end else if (v < -64'sd16384) begin
            q_new = -QUAT_LIM;
        end else begin
            q_new = v[QUAT_W-1:0];
        end
    end

    always_comb begin
        logic signed [ZW-1:0] ro, po;
        ro = (r_roll + ZW'(8)) >>> 4;
        po = (r_pitch + ZW'(8)) >>> 4;
        if (ro > ZW'(ROLL_LIM)) begin
            a_roll = ROLL_LIM;
        end else if (ro < -ZW'(ROLL_LIM)) begin
            a_roll = -ROLL_LIM;
        end else begin
            a_roll = ro[ROLL_W-1:0];
        end
        if (po > ZW'(PITCH_LIM)) begin
            a_pitch = PITCH_LIM;
        end else if (po < -ZW'(PITCH_LIM)) begin
            a_pitch = -PITCH_LIM;
        end else begin
            a_pitch = po[PITCH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm[0]     <= '0;
            r_sm[1]     <= '0;
            r_sm[2]     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_FILT_ACC) begin
                r_sm[i_cmd.axis] <= f_new;
            end
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_smp[0] <= smp_x;
            r_smp[1] <= smp_y;
            r_smp[2] <= smp_z;
        end
        case (i_cmd.op)
            OP_FILT_MUL: r_prod <= 64'(r_sm[i_cmd.axis]) * W_OLD;
            OP_V1_INIT, OP_V2_INIT: begin
                r_rot  <= 1'b0;
                r_zero <= (vi_x == '0) && (vi_y == '0);
                if (vi_x < 0) begin
                    r_cx <= -vi_x;
                    r_cy <= -vi_y;
                    r_cz <= (vi_y >= 0) ? PI_Q16 : -PI_Q16;
                end else begin
                    r_cx <= vi_x;
                    r_cy <= vi_y;
                    r_cz <= '0;
                end
            end
            OP_ITER: begin
                if (r_rot || !r_zero) begin
                    if (it_sigma) begin
                        r_cx <= r_cx - it_dx;
                        r_cy <= r_cy + it_dy;
                        r_cz <= r_cz - $signed(it_t);
                    end else begin
                        r_cx <= r_cx + it_dx;
                        r_cy <= r_cy - it_dy;
                        r_cz <= r_cz + $signed(it_t);
                    end
                end
            end
            OP_SCALE_MUL: begin
                r_roll <= r_cz;
                r_prod <= 64'(r_cx) * INV_GAIN_Q16;
            end
            OP_R1_INIT: begin
                r_pitch <= r_cz;
                r_rot   <= 1'b1;
                r_zero  <= 1'b0;
                r_cx    <= INV_GAIN_Q30;
                r_cy    <= '0;
                r_cz    <= r_roll;
            end
            OP_R2_INIT: begin
                r_cr <= r_cx;
                r_sr <= r_cy;
                r_cx <= INV_GAIN_Q30;
                r_cy <= '0;
                r_cz <= r_pitch;
            end
            OP_Q_MUL: r_prod <= q_a * q_b;
            OP_Q_RND: r_q[i_cmd.qsel] <= q_new;
            OP_OUT: begin
                r_ow     <= r_q[0];
                r_ox     <= r_q[1];
                r_oy     <= r_q[2];
                r_oz     <= r_q[3];
                r_oroll  <= a_roll;
                r_opitch <= a_pitch;
            end
            default: begin
            end
        endcase
    end

    assign o_status.out_busy    = r_out_valid && !o_result.ready;
    assign o_result.valid       = r_out_valid;
    assign o_result.quat_w      = r_ow;
    assign o_result.quat_x      = r_ox;
    assign o_result.quat_y      = r_oy;
    assign o_result.quat_z      = r_oz;
    assign o_result.roll_angle  = r_oroll;
    assign o_result.pitch_angle = r_opitch;

endmodule
`default_nettype wire

// File: tb/sv/tb_tilt_scoreboard.sv
// scoreboard class: tilt quaternion predictor and expected-word queue
`timescale 1ns / 1ps
class tilt_scoreboard;
    typedef struct packed {
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [14:0] roll;
        logic signed [13:0] pitch;
    } tilt_word_t;

    longint filt_x, filt_y, filt_z;
    tilt_word_t pending_words[$];
    int errors;

    function void clear_filter();
        filt_x = 0;
        filt_y = 0;
        filt_z = 0;
        errors = 0;
    endfunction

    static function longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    static function longint limit(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    static function longint atan_entry(int k);
        longint tbl[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2, 1};
        return k < 17 ? tbl[k] : 0;
    endfunction

    static function longint smooth(longint prev, logic signed [15:0] s);
        longint acc;
        acc = prev * 58982 + (longint'(s) <<< 10) * 6554;
        return limit(floor_shift(acc + 32768, 16), -(64'sd1 <<< 25), (64'sd1 <<< 25) - 1);
    endfunction

    static function longint vector_angle(longint vx, longint vy, output longint mag);
        longint ang, dx, dy;
        ang = 0;
        mag = 0;
        if (vx == 0 && vy == 0) return 0;
        if (vx < 0) begin
            ang = (vy >= 0) ? 205887 : -205887;
            vx = -vx;
            vy = -vy;
        end
        for (int i = 0; i < 16; i++) begin
            dx = floor_shift(vy, i % 32);
            dy = floor_shift(vx, i % 32);
            if (vy >= 0) begin
                vx += dx; vy -= dy; ang += atan_entry(i % 32);
            end else begin
                vx -= dx; vy += dy; ang -= atan_entry(i % 32);
            end
        end
        mag = vx;
        return ang;
    endfunction

    static function void half_sincos(longint a, output longint c, output longint s);
        longint rx, ry, rz, dx, dy, t;
        rx = 652032874;
        ry = 0;
        rz = a;
        for (int i = 0; i < 16; i++) begin
            dx = floor_shift(ry, i % 32);
            dy = floor_shift(rx, i % 32);
            t = 2 * atan_entry(i % 32);
            if (rz >= 0) begin
                rx -= dx; ry += dy; rz -= t;
            end else begin
                rx += dx; ry -= dy; rz += t;
            end
        end
        c = rx;
        s = ry;
    endfunction

    static function logic signed [15:0] quat_term(longint a, longint b);
        return 16'(limit(floor_shift(a * b + (64'sd1 <<< 45), 46), -16384, 16384));
    endfunction

    function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az);
        longint mag, r, roll_q, pitch_q, cr, sr, cp, sp;
        tilt_word_t w;
        filt_x = smooth(filt_x, ax);
        filt_y = smooth(filt_y, ay);
        filt_z = smooth(filt_z, az);
        roll_q = vector_angle(filt_z, filt_y, mag);
        r = floor_shift(mag * 39797 + 32768, 16);
        pitch_q = vector_angle(r, filt_x, mag);
        half_sincos(roll_q, cr, sr);
        half_sincos(pitch_q, cp, sp);
        w.qw = quat_term(cr, cp);
        w.qx = quat_term(sr, cp);
        w.qy = quat_term(cr, sp);
        w.qz = quat_term(-sr, sp);
        w.roll = 15'(limit(floor_shift(roll_q + 8, 4), -12868, 12868));
        w.pitch = 14'(limit(floor_shift(pitch_q + 8, 4), -6434, 6434));
        pending_words.push_back(w);
    endfunction

    function void check_word(tilt_word_t got);
        tilt_word_t exp_w;
        if (pending_words.size() == 0) begin
            $display("%0t: unexpected result word %h", $realtime, got);
            errors++;
            return;
        end
        exp_w = pending_words.pop_front();
        if (got !== exp_w) begin
            $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d roll=%0d pitch=%0d",
                     $realtime, exp_w.qw, exp_w.qx, exp_w.qy, exp_w.qz, exp_w.roll,
                     exp_w.pitch);
            $display("%0t:          actual w=%0d x=%0d y=%0d z=%0d roll=%0d pitch=%0d",
                     $realtime, got.qw, got.qx, got.qy, got.qz, got.roll, got.pitch);
            errors++;
        end
    endfunction
endclass

// File: tb/sv/tb.sv
// testbench top: drives samples, stalls the result side, checks every word
`timescale 1ns / 1ps
module tb;
    import atq_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int send_idle_pct = 8;
    int recv_idle_pct = 85;
    bit hold_off = 1'b0;
    tilt_scoreboard tilt_sb;

    atq_in_if  sample_ch();
    atq_out_if result_ch();

    accel_tilt_quaternion u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch.sink),
        .o_result (result_ch.source)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        sample_ch.valid = 1'b0;
        sample_ch.accel_x = '0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;
        result_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && sample_ch.valid && sample_ch.ready)
            tilt_sb.note_sample(sample_ch.accel_x, sample_ch.accel_y, sample_ch.accel_z);
        if (i_rst_n && result_ch.valid && result_ch.ready)
            tilt_sb.check_word({result_ch.quat_w, result_ch.quat_x, result_ch.quat_y,
                                result_ch.quat_z, result_ch.roll_angle,
                                result_ch.pitch_angle});
    end

    always @(negedge i_clk) begin
        if (hold_off)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // valid stays up after the accept, the next call or the caller drops it
    task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az);
        while ($urandom_range(99) < send_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.accel_x <= ax;
        sample_ch.accel_y <= ay;
        sample_ch.accel_z <= az;
        do @(posedge i_clk); while (!sample_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (tilt_sb.pending_words.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(signed'($urandom_range(400)) - 200);
            3: return 16'(signed'($urandom_range(8000)) + 8000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_run(int n);
        logic signed [15:0] bx, by, bz;
        bx = pick_axis(); by = pick_axis(); bz = pick_axis();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) begin
                bx = pick_axis(); by = pick_axis(); bz = pick_axis();
            end
            if ($urandom_range(3) == 0)
                send_sample(pick_axis(), pick_axis(), pick_axis());
            else
                send_sample(bx + 16'($urandom_range(64)) - 16'sd32,
                            by + 16'($urandom_range(64)) - 16'sd32,
                            bz + 16'($urandom_range(64)) - 16'sd32);
        end
        sample_ch.valid <= 1'b0;
    endtask

    initial begin
        tilt_sb = new();
        tilt_sb.clear_filter();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero vector, extremes, each quadrant, z negative with y zero
        send_sample(16'sd0, 16'sd0, 16'sd0);
        for (int i = 0; i < 4; i++) send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
        for (int i = 0; i < 4; i++) send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        for (int i = 0; i < 4; i++) send_sample(16'sd0, 16'sd0, 16'sh8000);
        for (int i = 0; i < 3; i++) send_sample(16'sh7fff, 16'sd0, 16'sd0);
        for (int i = 0; i < 3; i++) send_sample(16'sh8000, 16'sh8000, 16'sh7fff);
        for (int i = 0; i < 3; i++) send_sample(16'sd1, 16'sh7fff, 16'sh8000);
        send_sample(16'shaaaa, 16'sh5555, 16'shffff);
        send_sample(16'sh5555, 16'shaaaa, 16'sh0001);

        random_run(300);
        send_idle_pct = 85;
        recv_idle_pct = 8;
        random_run(300);
        drain();

        // long receiver stall while samples keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(negedge i_clk);
                hold_off = 1'b0;
            end
            random_run(20);
        join
        drain();
        random_run(300);
        drain();
        repeat (200) @(negedge i_clk);
        if (tilt_sb.errors == 0 && tilt_sb.pending_words.size() == 0)
            $display("accel_tilt_quaternion verification clean");
        else
            $display("accel_tilt_quaternion verification failed");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("accel_tilt_quaternion verification failed");
        $finish;
    end
endmodule
